/* rtl/uvst_pkg.sv */
// Shared types and codes for the unordered value set table.
package uvst_pkg;

    // Action codes carried on the input channel.
    localparam logic [2:0] ACT_ADD      = 3'd0;
    localparam logic [2:0] ACT_REMOVE   = 3'd1;
    localparam logic [2:0] ACT_CONTAINS = 3'd2;
    localparam logic [2:0] ACT_GET      = 3'd3;
    localparam logic [2:0] ACT_CLEAR    = 3'd4;

    // Error codes carried on the result channel.
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] member_value;
        logic [3:0]  entry_index;
    } uvst_in_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic [4:0]  member_count;
        logic [1:0]  error_code;
    } uvst_out_t;

    // Decoded operation handed from the front end to the execution side.
    typedef enum logic [2:0] {
        OP_ADD,
        OP_REMOVE,
        OP_CONTAINS,
        OP_GET,
        OP_CLEAR,
        OP_NOP
    } uvst_op_t;

    typedef struct packed {
        uvst_op_t    op;
        logic [31:0] member_value;
        logic [3:0]  entry_index;
    } uvst_cmd_t;

endpackage

/* rtl/uvst_front.sv */
// Front end: accepts input transfers and decodes them into commands.
module uvst_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  uvst_pkg::uvst_in_t  s_data,
    output logic                push_valid,
    input  logic                push_ready,
    output uvst_pkg::uvst_cmd_t push_data
);

    logic                valid_reg;
    uvst_pkg::uvst_cmd_t cmd_reg;
    uvst_pkg::uvst_cmd_t cmd_next;

    assign s_ready    = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_data  = cmd_reg;

    always_comb begin
        cmd_next.member_value = s_data.member_value;
        cmd_next.entry_index  = s_data.entry_index;
        case (s_data.action)
            uvst_pkg::ACT_ADD:      cmd_next.op = uvst_pkg::OP_ADD;
            uvst_pkg::ACT_REMOVE:   cmd_next.op = uvst_pkg::OP_REMOVE;
            uvst_pkg::ACT_CONTAINS: cmd_next.op = uvst_pkg::OP_CONTAINS;
            uvst_pkg::ACT_GET:      cmd_next.op = uvst_pkg::OP_GET;
            uvst_pkg::ACT_CLEAR:    cmd_next.op = uvst_pkg::OP_CLEAR;
            default:                cmd_next.op = uvst_pkg::OP_NOP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

/* rtl/uvst_queue.sv */
// Two-entry command queue between the front end and the execution side.
module uvst_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  uvst_pkg::uvst_cmd_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output uvst_pkg::uvst_cmd_t pop_data
);

    uvst_pkg::uvst_cmd_t slot_reg [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/uvst_back.sv */
// Execution side: keeps entries and count; one command per cycle unless stalled.
module uvst_back #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  uvst_pkg::uvst_cmd_t cmd,
    output logic                m_valid,
    input  logic                m_ready,
    output uvst_pkg::uvst_out_t m_data
);

    // Values arrive as 32 bits, so no more than 32 bits are ever stored.
    localparam int SW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [SW-1:0]       entries_reg  [CAPACITY];
    logic [SW-1:0]       entries_next [CAPACITY];
    logic [CW-1:0]       fill_reg;
    logic [CW-1:0]       fill_next;
    logic                m_valid_reg;
    uvst_pkg::uvst_out_t out_reg;
    uvst_pkg::uvst_out_t out_next;

    logic [SW-1:0]       value;
    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] shift_sel;
    logic                present;
    logic                acc;
    logic                hit;
    logic [SW-1:0]       rd;
    logic [1:0]          err;
    logic                do_exec;

    assign cmd_ready = !m_valid_reg || m_ready;
    assign do_exec   = cmd_valid && cmd_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign value     = cmd.member_value[SW-1:0];

    // Every live entry is compared at once; entries are distinct, so at most
    // one of them matches.
    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            match[k] = (k < int'(fill_reg)) && (entries_reg[k] == value);
        end
        present = |match;
        for (int k = 0; k < CAPACITY; k++) begin
            acc = 1'b0;
            for (int j = 0; j <= k; j++) begin
                acc = acc | match[j];
            end
            shift_sel[k] = acc;
        end
    end

    always_comb begin
        entries_next = entries_reg;
        fill_next    = fill_reg;
        hit          = 1'b0;
        rd           = '0;
        err          = uvst_pkg::ERR_NONE;
        case (cmd.op)
            uvst_pkg::OP_ADD: begin
                if (present) begin
                    hit = 1'b1;
                end else if (fill_reg == CW'(CAPACITY)) begin
                    err = uvst_pkg::ERR_FULL;
                end else begin
                    for (int k = 0; k < CAPACITY; k++) begin
                        if (k == int'(fill_reg)) begin
                            entries_next[k] = value;
                        end
                    end
                    fill_next = fill_reg + 1'b1;
                end
            end
            uvst_pkg::OP_REMOVE: begin
                if (present) begin
                    // Entries from the match upward slide down one place.
                    for (int k = 0; k < CAPACITY - 1; k++) begin
                        if (shift_sel[k]) begin
                            entries_next[k] = entries_reg[k + 1];
                        end
                    end
                    fill_next = fill_reg - 1'b1;
                    hit       = 1'b1;
                end
            end
            uvst_pkg::OP_CONTAINS: begin
                hit = present;
            end
            uvst_pkg::OP_GET: begin
                if ((int'(cmd.entry_index) < int'(fill_reg)) &&
                    (int'(cmd.entry_index) < CAPACITY)) begin
                    for (int k = 0; k < CAPACITY; k++) begin
                        if (k == int'(cmd.entry_index)) begin
                            rd = entries_reg[k];
                        end
                    end
                end else begin
                    err = uvst_pkg::ERR_RANGE;
                end
            end
            uvst_pkg::OP_CLEAR: begin
                fill_next = '0;
            end
            default: begin
            end
        endcase
        out_next.hit          = hit;
        out_next.read_value   = 32'(rd);
        out_next.member_count = 5'(fill_next);
        out_next.error_code   = err;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd_ready) begin
                m_valid_reg <= cmd_valid;
            end
            if (do_exec) begin
                fill_reg <= fill_next;
            end
        end
        if (do_exec) begin
            entries_reg <= entries_next;
            out_reg     <= out_next;
        end
    end

endmodule

/* rtl/unordered_value_set_table.sv */
// Top level of the unordered value set table.
//
// A set of distinct values kept in insertion order, up to CAPACITY entries.
// Each transfer on the s_ channel carries one action (add, remove, contains,
// get by index, clear) and produces exactly one transfer on the m_ channel
// with the hit flag, the read value, the count after the action and an
// error code. Values are compared in their low VALUE_WIDTH bits.
//
// An input transfer passes a decode register, a two-entry command queue and
// the execution stage with its result register before its result is offered.
// One action is carried out per cycle: all entries are compared in parallel
// and a remove shifts them in parallel, so while m_ready stays high the block
// sustains one transfer per cycle in each direction.
//
// When m_ready is low the result register holds; the queue then fills and
// s_ready drops once the decode register and both queue slots are occupied.
// Synchronous reset empties the set and drops both valid signals; stored
// entries are not cleared, since they are only read below the count.
module unordered_value_set_table #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  uvst_pkg::uvst_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output uvst_pkg::uvst_out_t m_data
);

    logic                push_valid;
    logic                push_ready;
    uvst_pkg::uvst_cmd_t push_data;
    logic                pop_valid;
    logic                pop_ready;
    uvst_pkg::uvst_cmd_t pop_data;

    uvst_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    uvst_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    uvst_back #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Only the three defined error codes are ever produced.
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.error_code == uvst_pkg::ERR_NONE ||
                     m_data.error_code == uvst_pkg::ERR_FULL ||
                     m_data.error_code == uvst_pkg::ERR_RANGE))
        else $error("undefined error code on result");

    // A rejected add happens only with the set at capacity.
    a_full_add: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.error_code == uvst_pkg::ERR_FULL) |->
            (!m_data.hit && m_data.member_count == 5'(CAPACITY)))
        else $error("full error reported below capacity");

    // An out-of-range get returns nothing.
    a_range_get: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.error_code == uvst_pkg::ERR_RANGE) |->
            (!m_data.hit && m_data.read_value == 32'd0))
        else $error("range error with data or hit");

    // A hit never comes with an error.
    a_hit_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.hit) |-> (m_data.error_code == uvst_pkg::ERR_NONE))
        else $error("hit reported together with an error");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the unordered value set table.
module testbench;
    import uvst_pkg::*;

    localparam int SET_CAPACITY = 16;
    localparam int POOL_SIZE    = 24;
    localparam int RANDOM_ITEMS = 1100;

    typedef struct packed {
        uvst_in_t  item;
        logic      typed;
        uvst_out_t result;
    } stim_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    uvst_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    uvst_out_t m_data;

    // Shadow copy of the set, updated at each accepted input transfer.
    logic [31:0] set_entries [SET_CAPACITY];
    int          set_count;
    uvst_out_t   expected_results [$];
    logic [31:0] value_pool [POOL_SIZE];
    int          mismatch_count;
    bit          send_burst;
    bit          recv_burst;

    unordered_value_set_table #(
        .CAPACITY    (SET_CAPACITY),
        .VALUE_WIDTH (32)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    function automatic uvst_out_t apply_set_action(input uvst_in_t item);
        uvst_out_t res;
        int        slot;
        int        k;
        res  = '0;
        slot = -1;
        for (k = 0; k < set_count; k++) begin
            if (slot < 0 && set_entries[k] == item.member_value) begin
                slot = k;
            end
        end
        case (item.action)
            ACT_ADD: begin
                if (slot >= 0) begin
                    res.hit = 1'b1;
                end else if (set_count >= SET_CAPACITY) begin
                    res.error_code = ERR_FULL;
                end else begin
                    set_entries[set_count] = item.member_value;
                    set_count++;
                end
            end
            ACT_REMOVE: begin
                if (slot >= 0) begin
                    for (k = slot; k < set_count - 1; k++) begin
                        set_entries[k] = set_entries[k + 1];
                    end
                    set_count--;
                    res.hit = 1'b1;
                end
            end
            ACT_CONTAINS: begin
                res.hit = (slot >= 0);
            end
            ACT_GET: begin
                if (int'(item.entry_index) < set_count) begin
                    res.read_value = set_entries[item.entry_index];
                end else begin
                    res.error_code = ERR_RANGE;
                end
            end
            ACT_CLEAR: begin
                set_count = 0;
            end
            default: begin
            end
        endcase
        res.member_count = 5'(set_count);
        return res;
    endfunction

    function automatic stim_row_t make_row(input logic [2:0] act, input logic [31:0] val,
                                           input logic [3:0] idx, input logic typed,
                                           input logic hit, input logic [31:0] rd,
                                           input logic [4:0] cnt, input logic [1:0] err);
        stim_row_t row;
        row.item.action        = act;
        row.item.member_value  = val;
        row.item.entry_index   = idx;
        row.typed              = typed;
        row.result.hit         = hit;
        row.result.read_value  = rd;
        row.result.member_count = cnt;
        row.result.error_code  = err;
        return row;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    // Drives one input transfer; called at a falling edge, returns at one.
    task automatic send_item(input uvst_in_t item, input logic typed,
                             input uvst_out_t typed_result);
        int        gap;
        uvst_out_t predicted;
        if ($urandom_range(0, 39) == 0) begin
            send_burst = !send_burst;
        end
        gap = send_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = apply_set_action(item);
        expected_results.push_back(typed ? typed_result : predicted);
        @(negedge aclk);
    endtask

    task automatic check_result(input uvst_out_t got);
        uvst_out_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with nothing pending", 32'(got), 32'd0);
            return;
        end
        want = expected_results.pop_front();
        if (got.hit !== want.hit)
            report_mismatch("hit", 32'(got.hit), 32'(want.hit));
        if (got.read_value !== want.read_value)
            report_mismatch("read_value", got.read_value, want.read_value);
        if (got.member_count !== want.member_count)
            report_mismatch("member_count", 32'(got.member_count), 32'(want.member_count));
        if (got.error_code !== want.error_code)
            report_mismatch("error_code", 32'(got.error_code), 32'(want.error_code));
    endtask

    // Result side: a random stall before each transfer.
    initial begin
        int gap;
        m_ready        = 1'b0;
        recv_burst     = 1'b0;
        mismatch_count = 0;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                recv_burst = !recv_burst;
            end
            gap = recv_burst ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            check_result(m_data);
            @(negedge aclk);
        end
    end

    initial begin
        stim_row_t  rows [$];
        uvst_in_t   item;
        int         add_weight;
        int         roll;
        int         n;
        s_valid        = 1'b0;
        s_data         = '0;
        aresetn        = 1'b0;
        set_count      = 0;
        send_burst     = 1'b0;
        for (n = 0; n < SET_CAPACITY; n++) begin
            set_entries[n] = '0;
        end

        // Small pool so that hits, duplicates and a full set are frequent.
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h0000_0001;
        for (n = 4; n < POOL_SIZE; n++) begin
            value_pool[n] = $urandom;
        end

        rows.push_back(make_row(ACT_GET, 32'h0, 4'd0, 1'b1, 1'b0, 32'h0, 5'd0, ERR_RANGE));
        rows.push_back(make_row(ACT_REMOVE, 32'h5, 4'd0, 1'b1, 1'b0, 32'h0, 5'd0, ERR_NONE));
        rows.push_back(make_row(ACT_ADD, 32'h0, 4'd0, 1'b1, 1'b0, 32'h0, 5'd1, ERR_NONE));
        rows.push_back(make_row(ACT_ADD, 32'hFFFF_FFFF, 4'd0, 1'b1, 1'b0, 32'h0, 5'd2,
                                ERR_NONE));
        rows.push_back(make_row(ACT_ADD, 32'h0, 4'd0, 1'b1, 1'b1, 32'h0, 5'd2, ERR_NONE));
        rows.push_back(make_row(ACT_GET, 32'h0, 4'd1, 1'b1, 1'b0, 32'hFFFF_FFFF, 5'd2,
                                ERR_NONE));
        rows.push_back(make_row(3'd7, 32'hFFFF_FFFF, 4'd15, 1'b1, 1'b0, 32'h0, 5'd2,
                                ERR_NONE));
        for (n = 0; n < 14; n++) begin
            rows.push_back(make_row(ACT_ADD, 32'h1 << (n + 18), 4'd0, 1'b0, 1'b0, 32'h0,
                                    5'd0, ERR_NONE));
        end
        rows.push_back(make_row(ACT_ADD, 32'h1234_5678, 4'd0, 1'b1, 1'b0, 32'h0, 5'd16,
                                ERR_FULL));
        rows.push_back(make_row(ACT_ADD, 32'h0, 4'd0, 1'b1, 1'b1, 32'h0, 5'd16, ERR_NONE));
        rows.push_back(make_row(ACT_GET, 32'h0, 4'd15, 1'b1, 1'b0, 32'h8000_0000, 5'd16,
                                ERR_NONE));
        rows.push_back(make_row(ACT_REMOVE, 32'hFFFF_FFFF, 4'd0, 1'b1, 1'b1, 32'h0, 5'd15,
                                ERR_NONE));
        rows.push_back(make_row(ACT_GET, 32'h0, 4'd1, 1'b0, 1'b0, 32'h0, 5'd0, ERR_NONE));
        rows.push_back(make_row(ACT_GET, 32'h0, 4'd15, 1'b1, 1'b0, 32'h0, 5'd15, ERR_RANGE));
        rows.push_back(make_row(ACT_CLEAR, 32'h0, 4'd0, 1'b1, 1'b0, 32'h0, 5'd0, ERR_NONE));

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (rows[r]) begin
            send_item(rows[r].item, rows[r].typed, rows[r].result);
        end

        add_weight = 40;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            // Shift the mix now and then so the count sweeps from empty to full.
            if (n % 80 == 0) begin
                add_weight = $urandom_range(10, 70);
            end
            roll = $urandom_range(0, 99);
            item.entry_index  = 4'($urandom_range(0, 15));
            item.member_value = ($urandom_range(0, 9) == 0) ? $urandom
                                : value_pool[$urandom_range(0, POOL_SIZE - 1)];
            if (roll < 3) begin
                item.action = 3'($urandom_range(5, 7));
            end else if (roll < 6) begin
                item.action = ACT_CLEAR;
            end else if (roll < 6 + add_weight) begin
                item.action = ACT_ADD;
            end else begin
                case ($urandom_range(0, 2))
                    0: item.action = ACT_REMOVE;
                    1: item.action = ACT_CONTAINS;
                    default: item.action = ACT_GET;
                endcase
            end
            send_item(item, 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        // Watch a little longer for results that nobody asked for.
        repeat (12) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/uvst_pkg.sv
rtl/uvst_front.sv
rtl/uvst_queue.sv
rtl/uvst_back.sv
rtl/unordered_value_set_table.sv
tb/sv/testbench.sv
